>>> rtl/tbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared types and constants for the transformed box bounds core.
// ----------------------------------------------------------------------------
package tbb_pkg;

   // register stages inside one output axis slice (multiply, select, sum, scale)
   localparam int AXIS_STAGES = 4;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      CSR_ROW_X   = 3'd0,
      CSR_ROW_Y   = 3'd1,
      CSR_ROW_Z   = 3'd2,
      CSR_SHIFT_X = 3'd3,
      CSR_SHIFT_Y = 3'd4,
      CSR_SHIFT_Z = 3'd5
   } csr_idx_type;

   // identity transform after reset
   localparam logic [47:0] ROW_X_RESET = 48'h0000_0000_1000;
   localparam logic [47:0] ROW_Y_RESET = 48'h0000_1000_0000;
   localparam logic [47:0] ROW_Z_RESET = 48'h1000_0000_0000;

   typedef struct packed {
      logic signed [31:0] src_min_x;
      logic signed [31:0] src_min_y;
      logic signed [31:0] src_min_z;
      logic signed [31:0] src_max_x;
      logic signed [31:0] src_max_y;
      logic signed [31:0] src_max_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_min_x;
      logic signed [31:0] out_min_y;
      logic signed [31:0] out_min_z;
      logic signed [31:0] out_max_x;
      logic signed [31:0] out_max_y;
      logic signed [31:0] out_max_z;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic        [30:0] half_x;
      logic        [30:0] half_y;
      logic        [30:0] half_z;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/transformed_box_bounds_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transformed_box_bounds_core
// Axis-aligned bounds of a box put through an affine transform.
// ----------------------------------------------------------------------------
// usage
//  - a source box beat (req_data) is taken at a rising edge with start high
//    and busy low; busy is never raised, so a new box may come every cycle
//  - the result beat appears on rsp_data with rsp_valid high for exactly
//    one cycle, after the axis pipeline and the output register; results leave in order
//  - the pipeline runs multiply, term select, three-term sum,
//    scale and saturate, then center and half-width; throughput one box
//    per cycle
//  - the receiver cannot stall, so nothing is held back and no buffering
//    is needed beyond the pipeline itself
//  - transform registers sit on the csr_ APB port, 64-bit data, register i
//    at byte address 8*i; write them only while no box is in flight
//  - synchronous reset clears the valid pipeline and loads the identity
//    transform with zero translation
// ----------------------------------------------------------------------------
module transformed_box_bounds_core
   import tbb_pkg::*;
(
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   // box request
   input  wire  logic                  start,
   output logic                        busy,
   input  wire  req_type               req_data,
   // result
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   // register port
   input  wire  logic                  csr_psel,
   input  wire  logic                  csr_penable,
   input  wire  logic                  csr_pwrite,
   input  wire  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic       [CSR_DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   // ---------------------------------------------------------------- registers
   logic [47:0] row_ff   [3];
   logic [31:0] shift_ff [3];
   logic        csr_wr;
   csr_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_idx_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= ROW_X_RESET;
         row_ff[1]   <= ROW_Y_RESET;
         row_ff[2]   <= ROW_Z_RESET;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_ROW_X:   row_ff[0]   <= csr_pwdata[47:0];
            CSR_ROW_Y:   row_ff[1]   <= csr_pwdata[47:0];
            CSR_ROW_Z:   row_ff[2]   <= csr_pwdata[47:0];
            CSR_SHIFT_X: shift_ff[0] <= csr_pwdata[31:0];
            CSR_SHIFT_Y: shift_ff[1] <= csr_pwdata[31:0];
            CSR_SHIFT_Z: shift_ff[2] <= csr_pwdata[31:0];
            default: ;  // unmapped offsets drop the write
         endcase
      end
   end

   // read mux, narrow registers zero-extended
   always_comb begin
      unique case (csr_idx)
         CSR_ROW_X:   csr_prdata = {16'd0, row_ff[0]};
         CSR_ROW_Y:   csr_prdata = {16'd0, row_ff[1]};
         CSR_ROW_Z:   csr_prdata = {16'd0, row_ff[2]};
         CSR_SHIFT_X: csr_prdata = {32'd0, shift_ff[0]};
         CSR_SHIFT_Y: csr_prdata = {32'd0, shift_ff[1]};
         CSR_SHIFT_Z: csr_prdata = {32'd0, shift_ff[2]};
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- input side
   // fully pipelined, never back-pressures the requester
   assign busy = 1'b0;

   logic            accept;
   logic [2:0][31:0] src_lo, src_hi;

   assign accept = start & ~busy;
   assign src_lo = {req_data.src_min_z, req_data.src_min_y, req_data.src_min_x};
   assign src_hi = {req_data.src_max_z, req_data.src_max_y, req_data.src_max_x};

   // valid bits travel beside the axis slices, one per stage
   logic [AXIS_STAGES-1:0] vld_ff, vld_in;

   assign vld_in = {vld_ff[AXIS_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- axis slices
   logic [31:0] mn [3];
   logic [31:0] mx [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      tbb_axis u_axis (
         .clock (clock),
         .lo    (src_lo),
         .hi    (src_hi),
         .row   (row_ff[a]),
         .shift (shift_ff[a]),
         .mn    (mn[a]),
         .mx    (mx[a])
      );
   end

   // ---------------------------------------------------------------- output stage
   // center: 33-bit sum, arithmetic shift; half: 33-bit difference, max >= min
   logic [32:0] ctr_sum [3];
   logic [32:0] hw_diff [3];
   rsp_type     rsp_in, rsp_ff;
   logic        rsp_valid_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ctr_sum[a] = {mn[a][31], mn[a]} + {mx[a][31], mx[a]};
         hw_diff[a] = {mx[a][31], mx[a]} - {mn[a][31], mn[a]};
      end
      rsp_in.out_min_x = mn[0];
      rsp_in.out_min_y = mn[1];
      rsp_in.out_min_z = mn[2];
      rsp_in.out_max_x = mx[0];
      rsp_in.out_max_y = mx[1];
      rsp_in.out_max_z = mx[2];
      rsp_in.center_x  = ctr_sum[0][32:1];
      rsp_in.center_y  = ctr_sum[1][32:1];
      rsp_in.center_z  = ctr_sum[2][32:1];
      rsp_in.half_x    = hw_diff[0][31:1];
      rsp_in.half_y    = hw_diff[1][31:1];
      rsp_in.half_z    = hw_diff[2][31:1];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[AXIS_STAGES-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
   // every taken box yields its result beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("result beat missing five cycles after box taken");

   // nothing comes out that was not put in
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result beat without a matching box");

   // bounds are ordered on all three axes and the x center lies between them
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.out_min_x) <= $signed(rsp_data.center_x)) &&
                    ($signed(rsp_data.center_x) <= $signed(rsp_data.out_max_x)) &&
                    ($signed(rsp_data.out_min_y) <= $signed(rsp_data.out_max_y)) &&
                    ($signed(rsp_data.out_min_z) <= $signed(rsp_data.out_max_z)))
      else $error("transformed bounds out of order");
`endif

endmodule
`default_nettype wire

>>> rtl/tbb_axis.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbb_axis
// One output axis: least and greatest transformed value over the box corners,
// picked term by term by comparing the two products, in a four-stage pipeline.
// ----------------------------------------------------------------------------
module tbb_axis
   import tbb_pkg::*;
(
   input  wire  logic              clock,
   input  wire  logic [2:0][31:0]  lo,
   input  wire  logic [2:0][31:0]  hi,
   input  wire  logic [47:0]       row,
   input  wire  logic [31:0]       shift,
   output logic       [31:0]       mn,
   output logic       [31:0]       mx
);

   logic signed [47:0] prod_lo_in [3];
   logic signed [47:0] prod_hi_in [3];
   logic signed [47:0] prod_lo_ff [3];
   logic signed [47:0] prod_hi_ff [3];
   logic signed [47:0] tmin_in    [3];
   logic signed [47:0] tmax_in    [3];
   logic signed [47:0] tmin_ff    [3];
   logic signed [47:0] tmax_ff    [3];
   logic signed [49:0] sum_min_in, sum_max_in;
   logic signed [49:0] sum_min_ff, sum_max_ff;
   logic signed [38:0] t_min, t_max;
   logic        [31:0] mn_in, mx_in;
   logic        [31:0] mn_ff, mx_ff;

   function automatic logic [31:0] sat32(input logic signed [38:0] v);
      logic same;
      same = (v[38:31] == {8{v[38]}});
      if (same) begin
         return v[31:0];
      end else begin
         return {v[38], {31{~v[38]}}};
      end
   endfunction

   // stage 1: both bounds times each coefficient
   always_comb begin
      for (int b = 0; b < 3; b++) begin
         prod_lo_in[b] = $signed(lo[b]) * $signed(row[b*16 +: 16]);
         prod_hi_in[b] = $signed(hi[b]) * $signed(row[b*16 +: 16]);
      end
   end

   // stage 2: smaller and larger product of each term
   always_comb begin
      for (int b = 0; b < 3; b++) begin
         tmin_in[b] = (prod_lo_ff[b] < prod_hi_ff[b]) ? prod_lo_ff[b] : prod_hi_ff[b];
         tmax_in[b] = (prod_lo_ff[b] < prod_hi_ff[b]) ? prod_hi_ff[b] : prod_lo_ff[b];
      end
   end

   // stage 3: sums of three terms
   assign sum_min_in = 50'(tmin_ff[0]) + 50'(tmin_ff[1]) + 50'(tmin_ff[2]);
   assign sum_max_in = 50'(tmax_ff[0]) + 50'(tmax_ff[1]) + 50'(tmax_ff[2]);

   // stage 4: floor by 4096, translate, saturate
   assign t_min = 39'($signed(sum_min_ff[49:12])) + 39'($signed(shift));
   assign t_max = 39'($signed(sum_max_ff[49:12])) + 39'($signed(shift));
   assign mn_in = sat32(t_min);
   assign mx_in = sat32(t_max);

   always_ff @(posedge clock) begin
      for (int b = 0; b < 3; b++) begin
         prod_lo_ff[b] <= prod_lo_in[b];
         prod_hi_ff[b] <= prod_hi_in[b];
         tmin_ff[b]    <= tmin_in[b];
         tmax_ff[b]    <= tmax_in[b];
      end
      sum_min_ff <= sum_min_in;
      sum_max_ff <= sum_max_in;
      mn_ff      <= mn_in;
      mx_ff      <= mx_in;
   end

   assign mn = mn_ff;
   assign mx = mx_ff;

endmodule
`default_nettype wire
